// ----- rtl/lz77enc_pkg.sv -----
// ----------------------------------------------------------------------------
// lz77enc_pkg
// Shared widths, codes, link types and code functions for the LZ77 token
// symbol encoder.
// ----------------------------------------------------------------------------
package lz77enc_pkg;

    // parameter defaults
    localparam int HISTORY_DEPTH_DEF     = 4;
    localparam int MAX_DISTANCE_BITS_DEF = 23;

    // field widths
    localparam int KIND_W      = 2;
    localparam int LIT_W       = 8;
    localparam int LEN_W       = 9;
    localparam int DIS_W       = 24;
    localparam int SYM_W       = 10;
    localparam int DSYM_W      = 8;
    localparam int EXTRA_W     = 28;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // code widths
    localparam int OSL_W       = 8;
    localparam int LEN_EXTRA_W = 6;
    localparam int LEN_COUNT_W = 3;
    localparam int LEN_BLEN_W  = 4;
    localparam int DIS_CODE_W  = 5;
    localparam int DIS_EXTRA_W = 23;

    // token kinds; any other code is an end of block
    localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_LEN_SYMBOL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_DIS_BASE   = 2'd1;

    localparam logic [SYM_W-1:0]  REPEAT_LEN_SYMBOL_RST = 10'd273;
    localparam logic [DSYM_W-1:0] REPEAT_DIS_BASE_RST   = 8'd24;

    localparam logic [LEN_W-1:0] MIN_LEN         = 9'd3;
    localparam logic [LEN_W-1:0] MAX_LEN         = 9'd258;
    localparam logic [DIS_W-1:0] MIN_DIS         = 24'd1;
    localparam logic [SYM_W-1:0] END_SYMBOL      = 10'd256;
    localparam logic [SYM_W-1:0] LEN_BASE_SYMBOL = 10'd257;
    localparam logic [COUNT_W-1:0] MAX_EXTRA_COUNT = 5'd28;

    // one link of the distance history chain
    typedef struct packed {
        logic             occupied;
        logic [DIS_W-1:0] distance;
    } t_cell_link;

    typedef struct packed {
        logic [SYM_W-1:0]       sym;
        logic [LEN_COUNT_W-1:0] count;
        logic [LEN_EXTRA_W-1:0] bits;
    } t_len_code;

    typedef struct packed {
        logic [DIS_CODE_W-1:0]  sym;
        logic [DIS_CODE_W-1:0]  count;
        logic [DIS_EXTRA_W-1:0] bits;
    } t_dis_code;

    // lookup stage to coder stage
    typedef struct packed {
        logic                   error;
        logic                   dvalid;
        logic [SYM_W-1:0]       sym;
        logic [DSYM_W-1:0]      dsym;
        logic [LEN_COUNT_W-1:0] len_count;
        logic [LEN_EXTRA_W-1:0] len_bits;
        logic [DIS_CODE_W-1:0]  dis_count;
    } t_token_info;

    // length code for a length of 3..258
    function automatic t_len_code f_length_code(input logic [LEN_W-1:0] len);
        logic [OSL_W-1:0]       osl;
        logic [LEN_BLEN_W-1:0]  b;
        logic [LEN_COUNT_W-1:0] n;
        t_len_code              c;
        osl = OSL_W'(len - MIN_LEN);
        b   = '0;
        for (int i = 0; i < OSL_W; i++) begin
            if (osl[i]) b = LEN_BLEN_W'(i + 1);
        end
        c = '0;
        if (osl < 8'd4) begin
            c.sym = LEN_BASE_SYMBOL + SYM_W'(osl);
        end else begin
            n       = LEN_COUNT_W'(b - 4'd2);
            c.count = n;
            c.bits  = LEN_EXTRA_W'(osl & ((8'd1 << n) - 8'd1));
            c.sym   = LEN_BASE_SYMBOL + 10'd4 + SYM_W'({b - 4'd3, 1'b0})
                      + SYM_W'(osl[n]);
        end
        return c;
    endfunction

    // distance code for an offset distance (distance minus one)
    function automatic t_dis_code f_distance_code(input logic [DIS_W-1:0] osd);
        logic [DIS_CODE_W-1:0] h;
        logic [DIS_W-1:0]      top;
        t_dis_code             c;
        h   = '0;
        top = '0;
        for (int i = 0; i < DIS_W; i++) begin
            if (osd[i]) begin
                h      = DIS_CODE_W'(i + 1);
                top    = '0;
                top[i] = 1'b1;
            end
        end
        c.sym   = h;
        c.count = (h == '0) ? '0 : h - 5'd1;
        c.bits  = DIS_EXTRA_W'(osd & ~top);
        return c;
    endfunction

endpackage

// ----- rtl/lz77enc_token_if.sv -----
// ----------------------------------------------------------------------------
// lz77enc_token_if
// Token channel: kind, literal byte, match length and match distance.
// ----------------------------------------------------------------------------
interface lz77enc_token_if;
    import lz77enc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [LIT_W-1:0]  literal;
    logic [LEN_W-1:0]  match_length;
    logic [DIS_W-1:0]  match_distance;

    modport source (output valid, kind, literal, match_length, match_distance,
                    input ready);
    modport sink   (input valid, kind, literal, match_length, match_distance,
                    output ready);
endinterface

// ----- rtl/lz77enc_symbol_if.sv -----
// ----------------------------------------------------------------------------
// lz77enc_symbol_if
// Symbol channel: len/lit symbol, distance symbol, extra bits and error.
// ----------------------------------------------------------------------------
interface lz77enc_symbol_if;
    import lz77enc_pkg::*;

    logic               valid;
    logic               ready;
    logic [SYM_W-1:0]   len_lit_symbol;
    logic               dis_symbol_valid;
    logic [DSYM_W-1:0]  dis_symbol;
    logic [EXTRA_W-1:0] extra_bits;
    logic [COUNT_W-1:0] extra_count;
    logic               error;

    modport source (output valid, len_lit_symbol, dis_symbol_valid, dis_symbol,
                    extra_bits, extra_count, error, input ready);
    modport sink   (input valid, len_lit_symbol, dis_symbol_valid, dis_symbol,
                    extra_bits, extra_count, error, output ready);
endinterface

// ----- rtl/lz77enc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lz77enc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lz77enc_cfg_if;
    import lz77enc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/lz77_token_symbol_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// lz77_token_symbol_encoder_unit
// Turns LZ77 tokens into len/lit symbols, distance symbols and extra bits,
// with a short history of recent distances for repeat codes.
// ----------------------------------------------------------------------------
// Usage:
//   i_token  : one token per transaction (literal, match or end of block).
//   o_symbol : exactly one result per token, in token order.
//   i_cfg    : register writes (index 0 repeat len symbol, index 1 repeat
//              distance base); always ready, write only while idle.
// Path: an accepted token passes the lookup register, then the output
//   register, before its result can be taken.
// Throughput: one token per cycle unless the output stalls. The history
//   chain is looked up and pushed in the cycle a token is accepted, so
//   back-to-back matches see each other.
// Reset: history emptied, previous length cleared, registers back to their
//   defaults, no result pending.
// Stall: while the receiver holds ready low, the output register keeps its
//   result, the lookup register holds one more token, and i_token.ready
//   falls once both are full.
// ----------------------------------------------------------------------------
module lz77_token_symbol_encoder_unit #(
    parameter int HISTORY_DEPTH     = lz77enc_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_DISTANCE_BITS = lz77enc_pkg::MAX_DISTANCE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lz77enc_token_if.sink    i_token,
    lz77enc_symbol_if.source o_symbol,
    lz77enc_cfg_if.sink      i_cfg
);
    import lz77enc_pkg::*;

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int DB_W   = MAX_DISTANCE_BITS - 1;

    logic [SYM_W-1:0]  r_repeat_len_symbol;
    logic [DSYM_W-1:0] r_repeat_dis_base;
    logic [LEN_W-1:0]  r_prev_len;
    logic              r_s1_valid;
    t_token_info       r_info;
    logic [DB_W-1:0]   r_dis_bits;

    t_token_info       n_info;
    logic [DB_W-1:0]   n_dis_bits;
    logic              n_push;

    logic              w_accept;
    logic              w_push;
    logic              w_coder_ready;
    logic [DIS_W-1:0]  w_osd;
    logic              w_len_ok;
    logic              w_dis_ok;
    t_len_code         w_lcode;
    t_dis_code         w_dcode;
    logic              w_hit;
    logic [SLOT_W-1:0] w_hit_slot;
    logic              w_match [HISTORY_DEPTH];
    t_cell_link        w_link  [HISTORY_DEPTH];

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_len_symbol <= REPEAT_LEN_SYMBOL_RST;
            r_repeat_dis_base   <= REPEAT_DIS_BASE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_REPEAT_LEN_SYMBOL: r_repeat_len_symbol <= i_cfg.data;
                CFG_REPEAT_DIS_BASE:   r_repeat_dis_base   <= DSYM_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

    // handshake: lookup register frees as the coder takes its token
    assign i_token.ready = !r_s1_valid || w_coder_ready;
    assign w_accept      = i_token.valid && i_token.ready;
    assign w_push        = w_accept && n_push;

    // history chain, newest distance in cell 0
    genvar j;
    generate
        for (j = 0; j < HISTORY_DEPTH; j++) begin : g_cell
            t_cell_link w_in;
            if (j == 0) begin : g_head
                assign w_in.occupied = 1'b1;
                assign w_in.distance = i_token.match_distance;
            end else begin : g_body
                assign w_in = w_link[j-1];
            end
            lz77enc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_push),
                .i_link  (w_in),
                .i_key   (i_token.match_distance),
                .o_link  (w_link[j]),
                .o_match (w_match[j])
            );
        end
    endgenerate

    // newest matching slot wins
    always_comb begin
        w_hit      = 1'b0;
        w_hit_slot = '0;
        for (int k = HISTORY_DEPTH - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_hit      = 1'b1;
                w_hit_slot = SLOT_W'(k);
            end
        end
    end

    // range checks and base codes
    assign w_osd    = i_token.match_distance - MIN_DIS;
    assign w_len_ok = (i_token.match_length >= MIN_LEN)
                      && (i_token.match_length <= MAX_LEN);
    assign w_dis_ok = (i_token.match_distance != '0)
                      && ((w_osd >> MAX_DISTANCE_BITS) == '0);
    assign w_lcode  = f_length_code(i_token.match_length);
    assign w_dcode  = f_distance_code(w_osd);

    // token decode into symbols; unused fields stay zero
    always_comb begin
        n_info     = '0;
        n_dis_bits = '0;
        n_push     = 1'b0;
        unique case (i_token.kind)
            KIND_LITERAL: begin
                n_info.sym = SYM_W'(i_token.literal);
            end
            KIND_MATCH: begin
                if (!(w_len_ok && w_dis_ok)) begin
                    n_info.error = 1'b1;
                end else begin
                    n_push = 1'b1;
                    if (w_match[0] && (r_prev_len == i_token.match_length)) begin
                        n_info.sym = r_repeat_len_symbol;
                    end else begin
                        n_info.sym       = w_lcode.sym;
                        n_info.dvalid    = 1'b1;
                        n_info.len_count = w_lcode.count;
                        n_info.len_bits  = w_lcode.bits;
                        if (w_hit) begin
                            n_info.dsym = r_repeat_dis_base + DSYM_W'(w_hit_slot);
                        end else begin
                            n_info.dsym      = DSYM_W'(w_dcode.sym);
                            n_info.dis_count = w_dcode.count;
                            n_dis_bits       = w_dcode.bits[DB_W-1:0];
                        end
                    end
                end
            end
            default: begin
                n_info.sym = END_SYMBOL;
            end
        endcase
    end

    // previous match length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_len <= '0;
        end else if (w_push) begin
            r_prev_len <= i_token.match_length;
        end
    end

    // lookup register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_coder_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_info     <= n_info;
            r_dis_bits <= n_dis_bits;
        end
    end

    lz77enc_coder #(
        .DB_W (DB_W)
    ) u_coder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s1_valid),
        .o_ready    (w_coder_ready),
        .i_info     (r_info),
        .i_dis_bits (r_dis_bits),
        .o_symbol   (o_symbol)
    );

    // a rejected match carries nothing but the flag
    a_error_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_symbol.valid && o_symbol.error |->
            !o_symbol.dis_symbol_valid && (o_symbol.extra_count == '0)
            && (o_symbol.len_lit_symbol == '0))
        else $error("error result carries symbol fields");

    // a push lands the distance in the newest cell
    a_push_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> w_link[0].occupied
            && (w_link[0].distance == $past(i_token.match_distance)))
        else $error("history head not updated on push");

    // occupied cells form an unbroken run from the head
    generate
        for (j = 1; j < HISTORY_DEPTH; j++) begin : g_occ_chk
            a_occ_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_link[j].occupied |-> w_link[j-1].occupied)
                else $error("history occupancy has a gap");
        end
    endgenerate

    // a full lookup register blocks new tokens while the coder stalls
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_coder_ready |-> !i_token.ready)
        else $error("token accepted over a stalled lookup register");

    // extra bit count never exceeds the field
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_symbol.valid |-> (o_symbol.extra_count <= MAX_EXTRA_COUNT))
        else $error("extra count out of range");

endmodule

// ----- rtl/lz77enc_cell.sv -----
// ----------------------------------------------------------------------------
// lz77enc_cell
// One slot of the recent-distance history. Holds a distance, compares it
// with the incoming key and passes its content down the chain on a push.
// ----------------------------------------------------------------------------
module lz77enc_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  lz77enc_pkg::t_cell_link        i_link,
    input  logic [lz77enc_pkg::DIS_W-1:0]  i_key,
    output lz77enc_pkg::t_cell_link        o_link,
    output logic                           o_match
);
    import lz77enc_pkg::*;

    logic             r_occupied;
    logic [DIS_W-1:0] r_distance;

    // occupancy is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occupied <= 1'b0;
        end else if (i_shift) begin
            r_occupied <= i_link.occupied;
        end
    end

    // distance payload, meaningful only while occupied
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_distance <= i_link.distance;
        end
    end

    assign o_link.occupied = r_occupied;
    assign o_link.distance = r_distance;
    assign o_match         = r_occupied && (r_distance == i_key);

endmodule

// ----- rtl/lz77enc_coder.sv -----
// ----------------------------------------------------------------------------
// lz77enc_coder
// Output stage: joins length and distance extra bits and holds the result
// in the output register until the transaction completes.
// ----------------------------------------------------------------------------
module lz77enc_coder #(
    parameter int DB_W = lz77enc_pkg::MAX_DISTANCE_BITS_DEF - 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  lz77enc_pkg::t_token_info  i_info,
    input  logic [DB_W-1:0]           i_dis_bits,
    lz77enc_symbol_if.source          o_symbol
);
    import lz77enc_pkg::*;

    logic               r_valid;
    logic [SYM_W-1:0]   r_sym;
    logic               r_dvalid;
    logic [DSYM_W-1:0]  r_dsym;
    logic [EXTRA_W-1:0] r_extra;
    logic [COUNT_W-1:0] r_count;
    logic               r_error;
    logic [EXTRA_W-1:0] n_extra;
    logic [COUNT_W-1:0] n_count;

    // length extra bits sit above the distance extra bits
    always_comb begin
        n_extra = (EXTRA_W'(i_info.len_bits) << i_info.dis_count)
                  | EXTRA_W'(i_dis_bits);
        n_count = COUNT_W'(i_info.len_count) + i_info.dis_count;
    end

    assign o_ready = !r_valid || o_symbol.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sym    <= i_info.sym;
            r_dvalid <= i_info.dvalid;
            r_dsym   <= i_info.dsym;
            r_extra  <= n_extra;
            r_count  <= n_count;
            r_error  <= i_info.error;
        end
    end

    assign o_symbol.valid            = r_valid;
    assign o_symbol.len_lit_symbol   = r_sym;
    assign o_symbol.dis_symbol_valid = r_dvalid;
    assign o_symbol.dis_symbol       = r_dsym;
    assign o_symbol.extra_bits       = r_extra;
    assign o_symbol.extra_count      = r_count;
    assign o_symbol.error            = r_error;

endmodule
